// ===== sv/edt_pkg.sv =====
// shared types and constants for the euclidean distance transform core
package edt_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int ADDR_W     = 16;
  localparam int CNT_W      = 17;
  localparam int ROW_W      = 9;
  localparam int SQ_W       = 27;
  localparam int DIST_W     = 14;
  localparam int STK_AW     = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ROW_W-1:0] ROW_INF   = ROW_W'(MAX_WIDTH);
  localparam logic [8:0]       MAX_W_V   = 9'(MAX_WIDTH);
  localparam logic [8:0]       MAX_H_V   = 9'(MAX_HEIGHT);
  localparam logic [SQ_W-1:0]  DIST_INF  = 27'd100000001;

  localparam logic [CFG_IDX_W-1:0] REG_IGNORE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FETCH,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_OUT,
    OP_BS_INIT,
    OP_BS_RD,
    OP_BS_WR,
    OP_COL_INIT,
    OP_COL_G0,
    OP_U_RD,
    OP_U_GET,
    OP_P_MUL,
    OP_REPLACE,
    OP_POP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_PUSH,
    OP_NEXT_U,
    OP_F_INIT,
    OP_F_MUL,
    OP_F_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   idle;
  } dp_cmd_t;

  typedef struct packed {
    logic load_last;
    logic bs_last;
    logic h_one;
    logic step_last;
    logic pop;
    logic top_zero;
    logic any_inf;
    logic u_last;
    logic f_last;
    logic col_last;
    logic out_busy;
  } dp_status_t;

  typedef enum logic [20:0] {
    S_IDLE    = 21'h000001,
    S_SQ_LD   = 21'h000002,
    S_SQRT    = 21'h000004,
    S_OUT     = 21'h000008,
    S_BS_INIT = 21'h000010,
    S_BS_RD   = 21'h000020,
    S_BS_WR   = 21'h000040,
    S_COL     = 21'h000080,
    S_COL_G0  = 21'h000100,
    S_U_RD    = 21'h000200,
    S_U_GET   = 21'h000400,
    S_P_RD    = 21'h000800,
    S_P_MUL   = 21'h001000,
    S_P_CMP   = 21'h002000,
    S_DIV     = 21'h004000,
    S_PUSH    = 21'h008000,
    S_U_END   = 21'h010000,
    S_F_INIT  = 21'h020000,
    S_F_RD    = 21'h040000,
    S_F_MUL   = 21'h080000,
    S_F_WR    = 21'h100000
  } state_t;

endpackage

// ===== sv/edt_ctrl.sv =====
// sequencer for load, transform passes and fetch of the distance transform
module edt_ctrl import edt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       func,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;
  dp_op_t op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_FETCH) begin
            op = OP_FETCH;
            state_next = S_SQ_LD;
          end else begin
            op = OP_LOAD;
            if (status.load_last) state_next = S_BS_INIT;
          end
        end
      end
      S_SQ_LD: begin
        op = OP_SQRT_INIT;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        op = OP_SQRT_STEP;
        if (status.step_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          op = OP_OUT;
          state_next = S_IDLE;
        end
      end
      S_BS_INIT: begin
        op = OP_BS_INIT;
        state_next = S_BS_RD;
      end
      S_BS_RD: begin
        op = OP_BS_RD;
        state_next = S_BS_WR;
      end
      S_BS_WR: begin
        op = OP_BS_WR;
        state_next = status.bs_last ? S_COL : S_BS_RD;
      end
      S_COL: begin
        op = OP_COL_INIT;
        state_next = S_COL_G0;
      end
      S_COL_G0: begin
        op = OP_COL_G0;
        state_next = status.h_one ? S_F_INIT : S_U_RD;
      end
      S_U_RD: begin
        op = OP_U_RD;
        state_next = S_U_GET;
      end
      S_U_GET: begin
        op = OP_U_GET;
        state_next = S_P_RD;
      end
      S_P_RD: begin
        state_next = S_P_MUL;
      end
      S_P_MUL: begin
        op = OP_P_MUL;
        state_next = S_P_CMP;
      end
      S_P_CMP: begin
        priority if (status.pop && status.top_zero) begin
          op = OP_REPLACE;
          state_next = S_U_END;
        end else if (status.pop) begin
          op = OP_POP;
          state_next = S_P_RD;
        end else if (status.any_inf) begin
          state_next = S_U_END;
        end else begin
          op = OP_DIV_INIT;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        op = OP_DIV_STEP;
        if (status.step_last) state_next = S_PUSH;
      end
      S_PUSH: begin
        op = OP_PUSH;
        state_next = S_U_END;
      end
      S_U_END: begin
        op = OP_NEXT_U;
        state_next = status.u_last ? S_F_INIT : S_U_RD;
      end
      S_F_INIT: begin
        op = OP_F_INIT;
        state_next = S_F_RD;
      end
      S_F_RD: begin
        state_next = S_F_MUL;
      end
      S_F_MUL: begin
        op = OP_F_MUL;
        state_next = S_F_WR;
      end
      S_F_WR: begin
        op = OP_F_WR;
        if (status.f_last) state_next = status.col_last ? S_IDLE : S_COL;
        else state_next = S_F_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign cmd.op   = op;
  assign cmd.idle = (state == S_IDLE);

  a_fetch_goes_to_root: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && func == FUNC_FETCH) |=> (state == S_SQ_LD))
    else $error("fetch did not start the root unit");

  a_last_load_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && func == FUNC_LOAD && status.load_last)
      |=> (state == S_BS_INIT))
    else $error("final load did not start the transform");

  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && status.out_busy) |=> (state == S_OUT))
    else $error("result dropped while output stalled");

endmodule

// ===== sv/edt_dp.sv =====
// datapath: stores, row scans, envelope stack, divider and square root unit
module edt_dp import edt_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  dp_op_t                      op,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic signed [31:0]          pixel_value,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [SQ_W-1:0]             squared_distance,
  output logic [DIST_W-1:0]           distance,
  output logic                        last_pixel,
  output logic                        result_valid,
  output dp_status_t                  status
);

  logic [ROW_W-1:0] row_mem [0:(MAX_WIDTH*MAX_HEIGHT)-1];
  logic [SQ_W-1:0]  sq_mem  [0:(MAX_WIDTH*MAX_HEIGHT)-1];
  logic [7:0]       cen_mem [0:MAX_HEIGHT-1];
  logic [8:0]       sep_mem [0:MAX_HEIGHT-1];
  logic [ROW_W-1:0] gv_mem  [0:MAX_HEIGHT-1];

  logic signed [31:0] ignore_reg;
  logic [8:0]         width_reg, height_reg;
  logic [CNT_W-1:0]   load_count, fetch_count;
  logic [7:0]         load_col;
  logic [ROW_W-1:0]   prev_d;
  logic [ADDR_W-1:0]  bs_addr, u_addr, f_addr;
  logic [7:0]         bs_col, col_x, u, stack_top;
  logic [ROW_W-1:0]   carry, gu;
  logic [16:0]        gu2, l_d2, l_g2, r_d2, nump, dnum;
  logic [9:0]         drem;
  logic [8:0]         den;
  logic [4:0]         cnt;
  logic [27:0]        sv;
  logic [16:0]        srem;
  logic [DIST_W-1:0]  root;
  logic [SQ_W-1:0]    sq_hold;
  logic               f_ok, f_lastp;

  logic [ROW_W-1:0]  row_rdata;
  logic [SQ_W-1:0]   sq_rdata;
  logic [7:0]        sq_c;
  logic [8:0]        tq;
  logic [ROW_W-1:0]  gs;

  logic [8:0]        eff_w, eff_h;
  logic [7:0]        w_m1, h_m1;
  logic [CNT_W-1:0]  total;

  logic              ld_restart;
  logic [CNT_W-1:0]  ld_idx, ld_next;
  logic [7:0]        ld_col;
  logic [ROW_W-1:0]  ld_d;
  logic              fe_full;
  logic [CNT_W-1:0]  fe_idx, fe_inc, fe_next;

  logic              row_we;
  logic [ADDR_W-1:0] row_waddr, row_raddr;
  logic [ROW_W-1:0]  row_wdata;
  logic              stk_we;
  logic [7:0]        stk_wa, stk_wc;
  logic [8:0]        stk_ws;
  logic [ROW_W-1:0]  stk_wg;

  logic [7:0]  lhs_d, rhs_d, fd;
  logic [17:0] lhs, rhs;
  logic        gs_inf;
  logic [17:0] num_full;
  logic [9:0]  drem_s;
  logic        dge;
  logic [17:0] wsep;
  logic        push_ok;
  logic [16:0] srem_s, trial;
  logic        sge;
  logic [SQ_W-1:0] f_val;
  logic [ROW_W-1:0] bs_cur;

  // effective image size
  always_comb begin
    if (width_reg == 9'd0) eff_w = 9'd1;
    else if (width_reg > MAX_W_V) eff_w = MAX_W_V;
    else eff_w = width_reg;
    if (height_reg == 9'd0) eff_h = 9'd1;
    else if (height_reg > MAX_H_V) eff_h = MAX_H_V;
    else eff_h = height_reg;
  end

  assign w_m1  = 8'(eff_w - 9'd1);
  assign h_m1  = 8'(eff_h - 9'd1);
  assign total = CNT_W'(18'(eff_w) * 18'(eff_h));

  // load path with forward row scan folded in
  assign ld_restart = (load_count >= total);
  assign ld_idx     = ld_restart ? '0 : load_count;
  assign ld_col     = ld_restart ? '0 : load_col;
  assign ld_next    = ld_idx + CNT_W'(1);

  always_comb begin
    if (pixel_value == ignore_reg) ld_d = '0;
    else if (ld_col == 8'd0) ld_d = ROW_INF;
    else if (prev_d >= ROW_INF) ld_d = ROW_INF;
    else ld_d = prev_d + ROW_W'(1);
  end

  assign fe_full = (load_count >= total);
  assign fe_idx  = (fetch_count >= total) ? '0 : fetch_count;
  assign fe_inc  = fe_idx + CNT_W'(1);
  assign fe_next = (fe_inc >= total) ? '0 : fe_inc;

  // envelope arithmetic
  assign gs_inf = (gs >= ROW_INF);
  assign lhs_d  = (tq >= 9'(sq_c)) ? 8'(tq - 9'(sq_c)) : 8'(9'(sq_c) - tq);
  assign rhs_d  = (tq >= 9'(u)) ? 8'(tq - 9'(u)) : 8'(9'(u) - tq);
  assign fd     = (u >= sq_c) ? (u - sq_c) : (sq_c - u);
  assign lhs    = 18'(l_d2) + 18'(l_g2);
  assign rhs    = 18'(r_d2) + 18'(gu2);
  assign num_full = 18'(nump) + 18'(gu2) - 18'(l_g2);
  assign drem_s = {drem[8:0], dnum[16]};
  assign dge    = (drem_s >= 10'(den));
  assign wsep   = 18'(dnum) + 18'd1;
  assign push_ok = (wsep < 18'(eff_h));
  assign srem_s = {srem[14:0], sv[27:26]};
  assign trial  = {1'b0, root, 2'b01};
  assign sge    = (srem_s >= trial);
  assign f_val  = gs_inf ? DIST_INF : SQ_W'(18'(l_d2) + 18'(l_g2));
  assign bs_cur = row_rdata;

  assign status.load_last = (ld_next == total);
  assign status.bs_last   = (bs_addr == '0);
  assign status.h_one     = (eff_h == 9'd1);
  assign status.step_last = (cnt == 5'd0);
  assign status.pop       = gs_inf ? (gu < ROW_INF) : ((gu < ROW_INF) && (lhs > rhs));
  assign status.top_zero  = (stack_top == 8'd0);
  assign status.any_inf   = gs_inf || (gu >= ROW_INF);
  assign status.u_last    = (u == h_m1);
  assign status.f_last    = (u == 8'd0);
  assign status.col_last  = (col_x == w_m1);
  assign status.out_busy  = out_valid && !out_ready;

  // store port selection
  always_comb begin
    row_we    = 1'b0;
    row_waddr = ld_idx[ADDR_W-1:0];
    row_wdata = ld_d;
    if (op == OP_LOAD) begin
      row_we = 1'b1;
    end else if (op == OP_BS_WR && bs_col != w_m1 && carry < bs_cur) begin
      row_we    = 1'b1;
      row_waddr = bs_addr;
      row_wdata = carry + ROW_W'(1);
    end
    unique case (op)
      OP_BS_RD:    row_raddr = bs_addr;
      OP_COL_INIT: row_raddr = ADDR_W'(col_x);
      default:     row_raddr = u_addr;
    endcase
  end

  always_comb begin
    stk_we = 1'b0;
    stk_wa = 8'd0;
    stk_wc = u;
    stk_ws = tq;
    stk_wg = gu;
    unique case (op)
      OP_COL_G0: begin
        stk_we = 1'b1;
        stk_wc = 8'd0;
        stk_ws = 9'd0;
        stk_wg = row_rdata;
      end
      OP_REPLACE: begin
        stk_we = 1'b1;
      end
      OP_PUSH: begin
        stk_we = push_ok;
        stk_wa = stack_top + 8'd1;
        stk_ws = wsep[8:0];
      end
      default: begin
        stk_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    row_rdata <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (op == OP_F_WR) sq_mem[f_addr] <= f_val;
    sq_rdata <= sq_mem[fe_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      cen_mem[stk_wa] <= stk_wc;
      sep_mem[stk_wa] <= stk_ws;
      gv_mem[stk_wa]  <= stk_wg;
    end
    sq_c <= cen_mem[stack_top];
    tq   <= sep_mem[stack_top];
    gs   <= gv_mem[stack_top];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_reg  <= 32'sh7FFFFFFF;
      width_reg   <= MAX_W_V;
      height_reg  <= MAX_H_V;
      load_count  <= '0;
      fetch_count <= '0;
      load_col    <= '0;
      stack_top   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready && op != OP_OUT) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_IGNORE) begin
          ignore_reg <= cfg_data;
        end else if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
          if (cfg_index == REG_WIDTH) width_reg <= cfg_data[8:0];
          else height_reg <= cfg_data[8:0];
          load_count  <= '0;
          fetch_count <= '0;
          load_col    <= '0;
        end
      end
      unique case (op)
        OP_LOAD: begin
          load_count <= ld_next;
          load_col   <= (ld_col == w_m1) ? 8'd0 : ld_col + 8'd1;
          prev_d     <= ld_d;
          if (ld_restart || status.load_last) fetch_count <= '0;
        end
        OP_FETCH: begin
          f_ok    <= fe_full;
          f_lastp <= fe_full && (fe_idx == total - CNT_W'(1));
          if (fe_full) fetch_count <= fe_next;
        end
        OP_SQRT_INIT: begin
          sq_hold <= f_ok ? sq_rdata : '0;
          sv      <= f_ok ? {1'b0, sq_rdata} : '0;
          srem    <= '0;
          root    <= '0;
          cnt     <= 5'(DIST_W - 1);
        end
        OP_SQRT_STEP: begin
          srem <= sge ? (srem_s - trial) : srem_s;
          root <= {root[DIST_W-2:0], sge};
          sv   <= {sv[25:0], 2'b00};
          cnt  <= cnt - 5'd1;
        end
        OP_OUT: begin
          out_valid        <= 1'b1;
          squared_distance <= sq_hold;
          distance         <= root;
          last_pixel       <= f_lastp;
          result_valid     <= f_ok;
        end
        OP_BS_INIT: begin
          bs_addr <= ADDR_W'(total - CNT_W'(1));
          bs_col  <= w_m1;
          col_x   <= 8'd0;
        end
        OP_BS_WR: begin
          // carry holds the already updated distance one column to the right
          if (bs_col == w_m1) carry <= bs_cur;
          else if (carry < bs_cur) carry <= carry + ROW_W'(1);
          else carry <= bs_cur;
          bs_addr <= bs_addr - ADDR_W'(1);
          bs_col  <= (bs_col == 8'd0) ? w_m1 : bs_col - 8'd1;
        end
        OP_COL_INIT: begin
          stack_top <= 8'd0;
          u         <= 8'd1;
          u_addr    <= ADDR_W'(eff_w) + ADDR_W'(col_x);
        end
        OP_U_GET: begin
          gu  <= row_rdata;
          gu2 <= 17'(18'(row_rdata) * 18'(row_rdata));
        end
        OP_P_MUL: begin
          l_d2 <= 17'(lhs_d * lhs_d);
          l_g2 <= 17'(18'(gs) * 18'(gs));
          r_d2 <= 17'(rhs_d * rhs_d);
          nump <= 17'(17'(u - sq_c) * (17'(u) + 17'(sq_c)));
        end
        OP_POP: begin
          stack_top <= stack_top - 8'd1;
        end
        OP_DIV_INIT: begin
          // intersection numerator is never negative once the top survived
          dnum <= num_full[16:0];
          drem <= '0;
          den  <= {u - sq_c, 1'b0};
          cnt  <= 5'd16;
        end
        OP_DIV_STEP: begin
          drem <= dge ? (drem_s - 10'(den)) : drem_s;
          dnum <= {dnum[15:0], dge};
          cnt  <= cnt - 5'd1;
        end
        OP_PUSH: begin
          if (push_ok) stack_top <= stack_top + 8'd1;
        end
        OP_NEXT_U: begin
          u      <= u + 8'd1;
          u_addr <= u_addr + ADDR_W'(eff_w);
        end
        OP_F_INIT: begin
          u      <= h_m1;
          f_addr <= ADDR_W'(total - CNT_W'(eff_w) + CNT_W'(col_x));
        end
        OP_F_MUL: begin
          l_d2 <= 17'(fd * fd);
          l_g2 <= 17'(18'(gs) * 18'(gs));
        end
        OP_F_WR: begin
          u      <= u - 8'd1;
          f_addr <= f_addr - ADDR_W'(eff_w);
          if (tq == 9'(u)) stack_top <= stack_top - 8'd1;
          if (u == 8'd0) col_x <= col_x + 8'd1;
        end
        default: begin
        end
      endcase
    end
  end

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_valid) |->
      (squared_distance == '0 && distance == '0 && !last_pixel))
    else $error("early fetch gave a nonzero result");

  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (28'(distance) * 28'(distance) <= 28'(squared_distance)))
    else $error("root exceeds square root of squared distance");

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= total)
    else $error("load count ran past image size");

  a_push_moves_top: assert property (@(posedge clk) disable iff (rst)
    (op == OP_PUSH && push_ok && !cfg_we) |=> (stack_top == $past(stack_top) + 8'd1))
    else $error("push did not advance stack top");

endmodule

// ===== sv/euclidean_distance_transform_core.sv =====
// top level of the exact 2d euclidean distance transform core
//
// channels: an input item carries func and pixel_value; func load (0) stores
// the next pixel in raster order, func fetch (1) returns one result item with
// squared_distance, distance, last_pixel and result_valid. a config write
// (cfg_index 0 ignore value, 1 width, 2 height) is taken only while idle.
// a load is stored straight from idle, so loads can follow back to back. the
// load that completes the image starts the transform, during which in_ready
// is low: a backward row scan that reads and updates each pixel, then per
// column an envelope pass that reads each row, pops or replaces the stack
// top and divides to place a pushed parabola, then a readback pass per row.
// a fetch runs a store read, a 14 step root unit and the output register.
// the result stays in the output register until out_ready; a following item is
// taken while it waits, but a second fetch holds until the register frees.
// reset restores the register defaults and empties the image; stores are not
// cleared, since every entry is written before it is read.
module euclidean_distance_transform_core import edt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  logic signed [31:0]   pixel_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SQ_W-1:0]      squared_distance,
  output logic [DIST_W-1:0]    distance,
  output logic                 last_pixel,
  output logic                 result_valid,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign in_ready  = cmd.idle;
  assign cfg_ready = cmd.idle && !in_valid;

  edt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .status   (status),
    .cmd      (cmd)
  );

  edt_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .op               (cmd.op),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pixel_value      (pixel_value),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .squared_distance (squared_distance),
    .distance         (distance),
    .last_pixel       (last_pixel),
    .result_valid     (result_valid),
    .status           (status)
  );

endmodule

// ===== verif/tb_euclidean_distance_transform_core.sv =====
// self-checking testbench for the euclidean distance transform core
module tb_euclidean_distance_transform_core;
  import edt_pkg::*;

  localparam int LIMIT      = 1500000;
  localparam int ITEM_GOAL  = 1350;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;

  typedef struct packed {
    logic [SQ_W-1:0]   sq;
    logic [DIST_W-1:0] root;
    logic              last;
    logic              vld;
  } edt_result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
    logic                 fn;
    logic [31:0]          pix;
    bit                   typed;
    edt_result_t          res;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready, func = 0;
  logic signed [31:0] pixel_value = 0;
  logic out_valid, out_ready = 0;
  logic [SQ_W-1:0] squared_distance;
  logic [DIST_W-1:0] distance;
  logic last_pixel, result_valid;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  euclidean_distance_transform_core DUT (.*);

  always #2 clk = ~clk;

  // shadow of the block state
  logic [31:0]      ign_val;
  logic [8:0]       width_reg, height_reg;
  logic [ROW_W-1:0] row_dist[STORE_SIZE];
  int unsigned      sq_dist[STORE_SIZE];
  int               env_center[MAX_HEIGHT], env_sep[MAX_HEIGHT];
  int unsigned      loaded, fetched;

  edt_result_t pending_results[$];
  int errors = 0, items_sent = 0, results_seen = 0, images_done = 0;
  int cycles = 0, send_idle = 38, recv_idle = 51;

  function automatic int unsigned clamp_size(logic [8:0] v, int mx);
    if (v == 0) return 1;
    return (v > mx) ? mx : v;
  endfunction

  function automatic longint row_sq(int w, int r, int c);
    logic [ROW_W-1:0] g;
    g = row_dist[r * w + c];
    if (g >= ROW_INF) return DIST_INF;
    return longint'(g) * g;
  endfunction

  function automatic longint parabola(longint y, longint i, longint g2);
    if (g2 == DIST_INF) return DIST_INF;
    return (y - i) * (y - i) + g2;
  endfunction

  function automatic logic [DIST_W-1:0] floor_root(longint v);
    logic [DIST_W-1:0] r;
    r = 0;
    for (int b = DIST_W - 1; b >= 0; b--)
      if (longint'(r | (1 << b)) * (r | (1 << b)) <= v) r = r | (1 << b);
    return r;
  endfunction

  task automatic compute_distances(int w, int h);
    int top, sq;
    longint gu2, gi2, wsep, num, v;
    for (int y = 0; y < h; y++)
      for (int x = w - 2; x >= 0; x--)
        if (row_dist[y*w+x+1] < row_dist[y*w+x]) row_dist[y*w+x] = row_dist[y*w+x+1] + 1;
    for (int x = 0; x < w; x++) begin
      top = 0;
      env_center[0] = 0;
      env_sep[0] = 0;
      for (int u = 1; u < h; u++) begin
        gu2 = row_sq(w, u, x);
        while (top >= 0) begin
          if (parabola(env_sep[top], env_center[top], row_sq(w, env_center[top], x)) >
              parabola(env_sep[top], u, gu2)) top--;
          else break;
        end
        if (top < 0) begin
          top = 0;
          env_center[0] = u;
        end else begin
          sq = env_center[top];
          gi2 = row_sq(w, sq, x);
          if (gu2 == DIST_INF || gi2 == DIST_INF) wsep = longint'(DIST_INF) + 1;
          else begin
            num = longint'(u) * u - longint'(sq) * sq + gu2 - gi2;
            wsep = 1 + num / (2 * (longint'(u) - sq));
          end
          if (wsep < h && top + 1 < MAX_HEIGHT) begin
            top++;
            env_center[top] = u;
            env_sep[top] = int'(wsep);
          end
        end
      end
      for (int u = h - 1; u >= 0 && top >= 0; u--) begin
        v = parabola(u, env_center[top], row_sq(w, env_center[top], x));
        if (v > DIST_INF) v = DIST_INF;
        sq_dist[u * w + x] = v;
        if (u == env_sep[top]) top--;
      end
    end
  endtask

  // advances the shadow state by one item, returns 1 with a result on fetch
  task automatic predict_item(logic fn, logic [31:0] pix, output bit has_res,
                              output edt_result_t res);
    int unsigned w, h, total, x;
    logic [ROW_W-1:0] d, prev;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    total = w * h;
    res = '0;
    has_res = (fn == FUNC_FETCH);
    if (fn == FUNC_LOAD) begin
      if (loaded >= total) begin
        loaded = 0;
        fetched = 0;
      end
      x = loaded % w;
      if (pix == ign_val) d = 0;
      else if (x == 0) d = ROW_INF;
      else begin
        prev = row_dist[loaded - 1];
        d = (prev >= ROW_INF) ? ROW_INF : prev + 1;
      end
      row_dist[loaded] = d;
      loaded++;
      if (loaded == total) begin
        fetched = 0;
        compute_distances(w, h);
        images_done++;
      end
    end else if (loaded >= total) begin
      if (fetched >= total) fetched = 0;
      res.sq = sq_dist[fetched];
      res.root = floor_root(sq_dist[fetched]);
      res.last = (fetched == total - 1);
      res.vld = 1;
      fetched++;
      if (fetched >= total) fetched = 0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // drives one item, leaves valid high so a following item can follow at once
  task automatic send_item(logic fn, logic [31:0] pix, bit typed = 0,
                           edt_result_t typed_res = '0);
    bit has_res;
    edt_result_t res;
    send_idle = (items_sent < 450) ? 38 : (items_sent < 900) ? 51 : 0;
    recv_idle = (items_sent < 450) ? 51 : (items_sent < 900) ? 38 : 0;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    func <= fn;
    pixel_value <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    predict_item(fn, pix, has_res, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    in_valid <= 0;
    while (pending_results.size() != 0 || !in_ready) @(posedge clk);
    // a load causes no result, so leave room for a transform still running
    repeat (40) @(posedge clk);
    while (!in_ready) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_IGNORE: ign_val = data;
      REG_WIDTH, REG_HEIGHT: begin
        if (idx == REG_WIDTH) width_reg = data[8:0];
        else height_reg = data[8:0];
        loaded = 0;
        fetched = 0;
      end
      default: ;
    endcase
  endtask

  // result side: random back-pressure and in-order check
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, sq", squared_distance, 0);
        end else begin
          automatic edt_result_t e = pending_results.pop_front();
          if (squared_distance !== e.sq) report_mismatch("squared_distance", squared_distance, e.sq);
          if (distance !== e.root) report_mismatch("distance", distance, e.root);
          if (last_pixel !== e.last) report_mismatch("last_pixel", last_pixel, e.last);
          if (result_valid !== e.vld) report_mismatch("result_valid", result_valid, e.vld);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_pixel(bit no_bg);
    logic [31:0] p;
    case ($urandom_range(9))
      0, 1, 2: p = ign_val;
      3, 4:    p = $urandom;
      default: p = $urandom_range(0, 3);
    endcase
    if (no_bg && p == ign_val) p = ign_val ^ 32'h1;
    return p;
  endfunction

  task automatic random_image(int phase);
    int unsigned w, h, total, n;
    bit no_bg, partial;
    if (phase == 1) begin
      write_reg(REG_WIDTH, 32'd511);
      write_reg(REG_HEIGHT, 32'd1);
    end else if (phase == 2) begin
      write_reg(REG_WIDTH, {$urandom} & 32'hFFFF_FE00 | 32'd1);
      write_reg(REG_HEIGHT, 32'd256);
    end else if (phase < 4 || $urandom_range(4) != 0) begin
      // mostly small images keep the transform short
      write_reg(REG_WIDTH, {$urandom} & 32'hFFFF_FE00 | $urandom_range(0, 9));
      write_reg(REG_HEIGHT, {$urandom} & 32'hFFFF_FE00 | $urandom_range(0, 9));
    end
    if ($urandom_range(3) == 0)
      write_reg(REG_IGNORE, $urandom_range(1) ? $urandom : $urandom_range(0, 3));
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    total = w * h;
    no_bg = ($urandom_range(7) == 0);
    partial = ($urandom_range(9) == 0) && total > 1;
    n = partial ? $urandom_range(1, total - 1) : total;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) send_item(FUNC_FETCH, $urandom);
      send_item(FUNC_LOAD, pick_pixel(no_bg));
    end
    n = partial ? $urandom_range(0, 3) : total + $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_item(FUNC_FETCH, $urandom);
  endtask

  localparam edt_result_t EMPTY_RES = '0;
  localparam edt_result_t ZERO_RES  = '{sq: 0, root: 0, last: 1, vld: 1};
  localparam edt_result_t INF_RES   = '{sq: DIST_INF, root: 14'd10000, last: 1, vld: 1};

  stim_row_t directed[] = '{
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_FETCH, 32'h0, 1, EMPTY_RES},
    '{ROW_CFG, 2'd3, 32'hDEAD_BEEF, FUNC_LOAD, 0, 0, EMPTY_RES},
    '{ROW_CFG, REG_WIDTH, 32'h0, FUNC_LOAD, 0, 0, EMPTY_RES},
    '{ROW_CFG, REG_HEIGHT, 32'hFFFF_FE01, FUNC_LOAD, 0, 0, EMPTY_RES},
    '{ROW_CFG, REG_IGNORE, 32'h8000_0000, FUNC_LOAD, 0, 0, EMPTY_RES},
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_LOAD, 32'h8000_0000, 0, EMPTY_RES},
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_FETCH, 32'hFFFF_FFFF, 1, ZERO_RES},
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_FETCH, 32'h0, 1, ZERO_RES},
    // reload over a finished image, this time with no background
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_LOAD, 32'h7FFF_FFFF, 0, EMPTY_RES},
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_FETCH, 32'h0, 1, INF_RES},
    '{ROW_CFG, REG_IGNORE, 32'h7FFF_FFFF, FUNC_LOAD, 0, 0, EMPTY_RES},
    '{ROW_CFG, REG_WIDTH, 32'd3, FUNC_LOAD, 0, 0, EMPTY_RES},
    '{ROW_CFG, REG_HEIGHT, 32'd2, FUNC_LOAD, 0, 0, EMPTY_RES},
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_LOAD, 32'h0, 0, EMPTY_RES},
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_LOAD, 32'h7FFF_FFFF, 0, EMPTY_RES},
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_FETCH, 32'h0, 1, EMPTY_RES},
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_LOAD, 32'hFFFF_FFFF, 0, EMPTY_RES},
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_LOAD, 32'h0, 0, EMPTY_RES},
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_LOAD, 32'h0, 0, EMPTY_RES},
    '{ROW_ITEM, REG_IGNORE, 0, FUNC_LOAD, 32'h7FFF_FFFF, 0, EMPTY_RES}
  };

  initial begin
    int phase;
    ign_val = 32'h7FFF_FFFF;
    width_reg = 9'd256;
    height_reg = 9'd256;
    loaded = 0;
    fetched = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) write_reg(directed[i].idx, directed[i].data);
      else send_item(directed[i].fn, directed[i].pix, directed[i].typed, directed[i].res);
    end
    // readout of the 3x2 image with wrap-around
    repeat (8) send_item(FUNC_FETCH, $urandom);
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      phase++;
      random_image(phase);
    end
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("ran %0d items over %0d image setups, %0d images transformed",
             items_sent, phase, images_done);
    $display("checked %0d results, %0d mismatches", results_seen, errors);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
